/* rtl/well_pkg.sv */
package well_pkg;

    localparam int unsigned RING_DEPTH_DEF = 624;
    localparam int unsigned WORD_W = 32;

    localparam int unsigned TAP_ONE = 70;
    localparam int unsigned TAP_TWO = 179;
    localparam int unsigned TAP_THREE = 449;

    localparam logic [WORD_W-1:0] TEMPER_B = 32'hE46E_1700;
    localparam logic [WORD_W-1:0] TEMPER_C = 32'h9B86_8000;
    localparam logic [WORD_W-1:0] TAP_MIX_MASK = 32'h0411_8000;

    localparam logic [1:0] TM_RAW = 2'd0;
    localparam logic [1:0] TM_SHIFT = 2'd1;
    localparam logic [1:0] TM_TAP = 2'd2;

    typedef logic [WORD_W-1:0] word_t;

    typedef struct packed {
        logic load;
        logic shift_right;
        logic shift_left;
    } cell_ctl_t;

    typedef struct packed {
        word_t w0;
        word_t w1;
        word_t w2;
        word_t w3;
        word_t wm1;
        word_t wm2;
    } well_taps_t;

endpackage

/* rtl/well_cell.sv */
module well_cell #(
    parameter int unsigned IDX_W = 10,
    parameter int unsigned CELL_INDEX = 0
) (
    input  logic              clk,
    input  well_pkg::cell_ctl_t ctl,
    input  logic [IDX_W-1:0]  load_cell,
    input  well_pkg::word_t   load_data,
    input  well_pkg::word_t   prev_word,
    input  well_pkg::word_t   succ_word,
    output well_pkg::word_t   word
);
    import well_pkg::*;

    word_t word_reg;
    word_t word_next;

    always_comb
    begin
        word_next = word_reg;
        if (ctl.load && (load_cell == IDX_W'(CELL_INDEX)))
        begin
            word_next = load_data;
        end
        else if (ctl.shift_right)
        begin
            word_next = prev_word;
        end
        else if (ctl.shift_left)
        begin
            word_next = succ_word;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign word = word_reg;

endmodule

/* rtl/well_ring.sv */
module well_ring #(
    parameter int unsigned RING_DEPTH = well_pkg::RING_DEPTH_DEF,
    parameter int unsigned IDX_W = $clog2(RING_DEPTH)
) (
    input  logic                 clk,
    input  well_pkg::cell_ctl_t  ctl,
    input  logic [IDX_W-1:0]     load_cell,
    input  well_pkg::word_t      load_data,
    input  well_pkg::word_t      new_head,
    input  well_pkg::word_t      new_second,
    output well_pkg::well_taps_t taps
);
    import well_pkg::*;

    word_t cell_word [RING_DEPTH];

    for (genvar k = 0; k < RING_DEPTH; k++)
    begin : g_cell
        word_t prev_word;
        word_t succ_word;

        if (k == 0)
        begin : g_first
            assign prev_word = new_head;
        end
        else if (k == 1)
        begin : g_second
            assign prev_word = new_second;
        end
        else
        begin : g_rest
            assign prev_word = cell_word[k-1];
        end

        assign succ_word = cell_word[(k + 1) % RING_DEPTH];

        well_cell #(
            .IDX_W      (IDX_W),
            .CELL_INDEX (k)
        ) u_cell (
            .clk       (clk),
            .ctl       (ctl),
            .load_cell (load_cell),
            .load_data (load_data),
            .prev_word (prev_word),
            .succ_word (succ_word),
            .word      (cell_word[k])
        );
    end

    assign taps.w0  = cell_word[0];
    assign taps.w1  = cell_word[TAP_ONE];
    assign taps.w2  = cell_word[TAP_TWO];
    assign taps.w3  = cell_word[TAP_THREE];
    assign taps.wm1 = cell_word[RING_DEPTH-1];
    assign taps.wm2 = cell_word[RING_DEPTH-2];

endmodule

/* rtl/well_recur.sv */
module well_recur (
    input  well_pkg::well_taps_t taps,
    input  logic [1:0]           temper_mode,
    output well_pkg::word_t      new_head,
    output well_pkg::word_t      new_second,
    output well_pkg::word_t      result
);
    import well_pkg::*;

    word_t z0;
    word_t z1;
    word_t z2;
    word_t n0;
    word_t n1;
    word_t t1;

    always_comb
    begin
        z0 = {taps.wm1[WORD_W-1], taps.wm2[WORD_W-2:0]};
        z1 = taps.w0 ^ (taps.w0 << 25) ^ taps.w1 ^ (taps.w1 >> 27);
        z2 = (taps.w2 >> 9) ^ taps.w3 ^ (taps.w3 >> 1);
        n1 = z1 ^ z2;
        n0 = z0 ^ z1 ^ (z1 << 9) ^ z2 ^ (z2 << 21) ^ n1 ^ (n1 >> 21);
        t1 = n0 ^ ((n0 << 7) & TEMPER_B);
        case (temper_mode)
            TM_SHIFT: result = t1 ^ ((t1 << 15) & TEMPER_C);
            TM_TAP:   result = n0 ^ (taps.w2 & TAP_MIX_MASK);
            default:  result = n0;
        endcase
    end

    assign new_head = n0;
    assign new_second = n1;

endmodule

/* rtl/well_obuf.sv */
module well_obuf (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  well_pkg::word_t push_data,
    input  logic            pop,
    output logic            full,
    output logic            valid,
    output well_pkg::word_t data
);
    import well_pkg::*;

    word_t      front_reg;
    word_t      front_next;
    word_t      skid_reg;
    word_t      skid_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    always_comb
    begin
        front_next = front_reg;
        skid_next = skid_reg;
        count_next = count_reg;
        case ({push, pop})
            2'b10:
            begin
                if (count_reg == 2'd0)
                begin
                    front_next = push_data;
                end
                else
                begin
                    skid_next = push_data;
                end
                count_next = count_reg + 2'd1;
            end
            2'b11:
            begin
                if (count_reg == 2'd1)
                begin
                    front_next = push_data;
                end
                else
                begin
                    front_next = skid_reg;
                    skid_next = push_data;
                end
            end
            2'b01:
            begin
                front_next = skid_reg;
                count_next = count_reg - 2'd1;
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        front_reg <= front_next;
        skid_reg <= skid_next;
    end

    assign full = (count_reg == 2'd2);
    assign valid = (count_reg != 2'd0);
    assign data = front_reg;

endmodule

/* rtl/well19937_prng_generator_core.sv */
// WELL19937a generator core.
// Input channel (in_valid/in_stall, kind, seed_word): kind 0 loads seed_word
// at the next load position, kind 1 generates one word. Output channel
// (out_valid/out_stall, random_word) carries one transaction per generate.
// cfg_wr_en/cfg_wr_data write temper_mode; write it only while idle.
// The state lives in a line of 624 word cells; a generate shifts the whole
// line by one cell with the two new words entering at its head, so one
// transaction is taken every cycle while in_stall is low. A generated word is
// registered in the output queue before it appears on the output.
// A load after generates returns the head to zero by rotating the cell line
// one cell per cycle, with in_stall high until the head is back at zero.
// Loads with the head at zero cause no alignment stall.
// A two-entry output queue keeps input flowing while a result waits; it
// raises in_stall only when both entries are held by a stalled receiver.
// Reset clears the head, load position, temper mode and the output queue; the
// cell contents are undefined, so load all 624 words before generating.
module well19937_prng_generator_core #(
    parameter int unsigned RING_DEPTH = well_pkg::RING_DEPTH_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    input  logic            kind,
    input  well_pkg::word_t seed_word,
    output logic            out_valid,
    input  logic            out_stall,
    output well_pkg::word_t random_word,
    input  logic            cfg_wr_en,
    input  logic [1:0]      cfg_wr_data
);
    import well_pkg::*;

    localparam int unsigned IDX_W = $clog2(RING_DEPTH);

    typedef enum logic [1:0] {
        ST_RUN   = 2'b01,
        ST_ALIGN = 2'b10
    } well_state_t;

    well_state_t      state_reg;
    well_state_t      state_next;
    logic [IDX_W-1:0] head_reg;
    logic [IDX_W-1:0] head_next;
    logic [IDX_W-1:0] load_pos_reg;
    logic [IDX_W-1:0] load_pos_next;
    logic [1:0]       temper_mode_reg;

    logic             take;
    logic             gen;
    logic             ld;
    logic             obuf_full;
    logic [IDX_W-1:0] load_cell;
    cell_ctl_t        ctl;
    well_taps_t       taps;
    word_t            new_head;
    word_t            new_second;
    word_t            result;

    assign in_stall = (state_reg == ST_ALIGN) || obuf_full;
    assign take = in_valid && !in_stall;
    assign gen = take && kind;
    assign ld = take && !kind;

    always_comb
    begin
        if (load_pos_reg >= head_reg)
        begin
            load_cell = load_pos_reg - head_reg;
        end
        else
        begin
            load_cell = IDX_W'({1'b0, load_pos_reg} + (IDX_W+1)'(RING_DEPTH)
                               - {1'b0, head_reg});
        end
    end

    assign ctl.load = ld;
    assign ctl.shift_right = gen;
    assign ctl.shift_left = (state_reg == ST_ALIGN);

    always_comb
    begin
        state_next = state_reg;
        head_next = head_reg;
        load_pos_next = load_pos_reg;
        case (state_reg)
            ST_RUN:
            begin
                if (gen)
                begin
                    head_next = (head_reg == '0) ? IDX_W'(RING_DEPTH - 1)
                                                 : head_reg - IDX_W'(1);
                end
                if (ld)
                begin
                    load_pos_next = (load_pos_reg == IDX_W'(RING_DEPTH - 1))
                                    ? '0 : load_pos_reg + IDX_W'(1);
                    if (head_reg != '0)
                    begin
                        state_next = ST_ALIGN;
                    end
                end
            end
            ST_ALIGN:
            begin
                if (head_reg == IDX_W'(RING_DEPTH - 1))
                begin
                    head_next = '0;
                    state_next = ST_RUN;
                end
                else
                begin
                    head_next = head_reg + IDX_W'(1);
                end
            end
            default:
            begin
                state_next = ST_RUN;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_RUN;
            head_reg <= '0;
            load_pos_reg <= '0;
            temper_mode_reg <= TM_RAW;
        end
        else
        begin
            state_reg <= state_next;
            head_reg <= head_next;
            load_pos_reg <= load_pos_next;
            if (cfg_wr_en)
            begin
                temper_mode_reg <= cfg_wr_data;
            end
        end
    end

    well_ring #(
        .RING_DEPTH (RING_DEPTH),
        .IDX_W      (IDX_W)
    ) u_ring (
        .clk        (clk),
        .ctl        (ctl),
        .load_cell  (load_cell),
        .load_data  (seed_word),
        .new_head   (new_head),
        .new_second (new_second),
        .taps       (taps)
    );

    well_recur u_recur (
        .taps        (taps),
        .temper_mode (temper_mode_reg),
        .new_head    (new_head),
        .new_second  (new_second),
        .result      (result)
    );

    well_obuf u_obuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (gen),
        .push_data (result),
        .pop       (out_valid && !out_stall),
        .full      (obuf_full),
        .valid     (out_valid),
        .data      (random_word)
    );

endmodule

/* rtl/well_chk.sv */
module well_chk (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        kind,
    input logic        out_valid,
    input logic        out_stall,
    input logic [31:0] random_word
);

    a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(random_word))
        else $error("stalled result changed or dropped");

    a_gen_shows: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && kind && !out_valid |=> out_valid)
        else $error("generate transaction gave no result");

    a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && !kind && !out_valid |=> !out_valid)
        else $error("load transaction gave a result");

    a_fill_stall: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && kind && out_valid && out_stall |=> in_stall)
        else $error("queue overrun not held off");

endmodule

bind well19937_prng_generator_core well_chk u_well_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .kind        (kind),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .random_word (random_word)
);
